// ===== rtl/scht_pkg.sv =====
// Shared constants, types and table-building functions for the sine/cosine table.
package scht_pkg;

  // Interpolator word: slopes and differences in units of 2^-46
  localparam int HW = 52;
  localparam int MW = HW - 1;
  localparam int LW = 26;

  localparam int PHASE_LAT = 4;
  localparam int ROM_LAT   = 2;
  localparam int HERM_LAT  = 15;
  localparam int TOTAL_LAT = PHASE_LAT + ROM_LAT + HERM_LAT + 1;

  // 1/(2*pi) in Q0.32
  localparam logic [29:0] TURN_SCALE  = 30'd683565276;
  // 2*pi in Q32.32
  localparam logic [63:0] TWO_PI_Q32  = 64'd26986075409;
  // pi/2 in Q2.62
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

  typedef logic signed [31:0]   sample_t;
  typedef logic signed [HW-1:0] wide_t;

  localparam sample_t ONE_Q30     = 32'sd1073741824;
  localparam sample_t NEG_ONE_Q30 = -32'sd1073741824;

  // Taylor divisors (2k)*(2k+1) for k = 1..8
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef struct packed {
    wide_t       c2;
    wide_t       e1;
    sample_t     f1;
    logic [31:0] fr;
  } herm_side_t;

  // (a*b) >> s with the full 128-bit product
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int unsigned s);
    logic [127:0] p;
    p = {64'b0, a} * {64'b0, b};
    return p[s +: 64];
  endfunction

  // Sine of a Q0.32 phase in turns, Q1.30; used only when the table is built
  function automatic sample_t sin_phase(input logic [31:0] phase);
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    int          k;
    r = {34'b0, phase[29:0]};
    if (phase[30]) begin
      r = 64'h4000_0000 - r;
    end
    x    = mul_shr(r, HALF_PI_Q62, 30);
    x2   = mul_shr(x, x, 62);
    term = x;
    sum  = x;
    for (k = 0; k < 8; k++) begin
      term = mul_shr(term, x2, 62) / TAYLOR_DIV[k];
      if (k[0] == 1'b0) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    q = (sum + 64'h8000_0000) >> 32;
    if (q > 64'd1073741824) begin
      q = 64'd1073741824;
    end
    return phase[31] ? -$signed(q[31:0]) : $signed(q[31:0]);
  endfunction

endpackage

// ===== rtl/scht_phase.sv =====
// Angle to table index, quarter-shifted index and fraction, four register stages.
module scht_phase #(
  parameter int TABLE_SIZE = 512,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 v_in,
  input  logic signed [31:0]   angle,
  output logic                 v_out,
  output logic                 neg,
  output logic [IW-1:0]        idx_s,
  output logic [IW-1:0]        idx_c,
  output logic [31:0]          fr
);
  import scht_pkg::*;

  logic          v0, v1, v2;
  logic          neg0, neg1, neg2;
  logic [31:0]   mag0;
  logic [61:0]   prod;
  logic [31:0]   phase1;
  logic [IW+31:0] scaled;
  logic [IW-1:0] idx2;
  logic [31:0]   fr2;
  logic [IW:0]   csum;
  logic [IW:0]   cwrap;

  assign prod   = 62'(mag0) * 62'(TURN_SCALE);
  assign scaled = (IW+32)'(phase1) * (IW+32)'(TABLE_SIZE);
  assign csum   = (IW+1)'(idx2) + (IW+1)'(TABLE_SIZE / 4);
  assign cwrap  = (csum >= (IW+1)'(TABLE_SIZE)) ? csum - (IW+1)'(TABLE_SIZE) : csum;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      v_out <= 1'b0;
    end else begin
      v0    <= v_in;
      v1    <= v0;
      v2    <= v1;
      v_out <= v2;
    end
    // most negative angle wraps to 2^31, which is its exact magnitude
    neg0   <= angle[31];
    mag0   <= angle[31] ? $unsigned(-angle) : $unsigned(angle);
    neg1   <= neg0;
    phase1 <= prod[58:27];
    neg2   <= neg1;
    idx2   <= scaled[IW+31:32];
    fr2    <= scaled[31:0];
    neg    <= neg2;
    idx_s  <= idx2;
    idx_c  <= IW'(cwrap);
    fr     <= fr2;
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    v_out |-> ({1'b0, idx_s} < (IW+1)'(TABLE_SIZE)) && ({1'b0, idx_c} < (IW+1)'(TABLE_SIZE)))
    else $error("table index out of range");

endmodule

// ===== rtl/scht_rom.sv =====
// Sine table split into even and odd banks; returns both neighbor pairs, registered.
module scht_rom #(
  parameter int TABLE_SIZE = 512,
  localparam int IW = $clog2(TABLE_SIZE)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                v_in,
  input  logic [IW-1:0]       idx_s,
  input  logic [IW-1:0]       idx_c,
  input  logic [31:0]         fr_in,
  output logic                v_out,
  output scht_pkg::sample_t   s_lo,
  output scht_pkg::sample_t   s_hi,
  output scht_pkg::sample_t   c_lo,
  output scht_pkg::sample_t   c_hi,
  output logic [31:0]         fr_out
);
  import scht_pkg::*;

  localparam int NE  = TABLE_SIZE / 2 + 1;
  localparam int NO  = TABLE_SIZE / 2;
  localparam int EAW = $clog2(NE);
  localparam int OAW = $clog2(NO);

  typedef sample_t even_rom_t [NE];
  typedef sample_t odd_rom_t  [NO];

  function automatic even_rom_t build_even();
    even_rom_t   arr;
    logic [63:0] ph;
    int          i;
    for (i = 0; i < NE; i++) begin
      ph     = (64'(2 * i) << 32) / TABLE_SIZE;
      arr[i] = sin_phase(ph[31:0]);
    end
    return arr;
  endfunction

  function automatic odd_rom_t build_odd();
    odd_rom_t    arr;
    logic [63:0] ph;
    int          i;
    for (i = 0; i < NO; i++) begin
      ph     = (64'(2 * i + 1) << 32) / TABLE_SIZE;
      arr[i] = sin_phase(ph[31:0]);
    end
    return arr;
  endfunction

  localparam even_rom_t EVEN_ROM = build_even();
  localparam odd_rom_t  ODD_ROM  = build_odd();

  logic [EAW-1:0] ea_s, ea_c;
  logic [OAW-1:0] oa_s, oa_c;
  sample_t        es_r, os_r, ec_r, oc_r;
  logic           lsb_s, lsb_c, v_r;
  logic [31:0]    fr_r;

  // entries i and i+1 always sit in opposite banks
  assign ea_s = EAW'(idx_s >> 1) + EAW'(idx_s[0]);
  assign oa_s = OAW'(idx_s >> 1);
  assign ea_c = EAW'(idx_c >> 1) + EAW'(idx_c[0]);
  assign oa_c = OAW'(idx_c >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_r   <= 1'b0;
      v_out <= 1'b0;
    end else begin
      v_r   <= v_in;
      v_out <= v_r;
    end
    es_r   <= EVEN_ROM[ea_s];
    os_r   <= ODD_ROM[oa_s];
    ec_r   <= EVEN_ROM[ea_c];
    oc_r   <= ODD_ROM[oa_c];
    lsb_s  <= idx_s[0];
    lsb_c  <= idx_c[0];
    fr_r   <= fr_in;
    s_lo   <= lsb_s ? os_r : es_r;
    s_hi   <= lsb_s ? es_r : os_r;
    c_lo   <= lsb_c ? oc_r : ec_r;
    c_hi   <= lsb_c ? ec_r : oc_r;
    fr_out <= fr_r;
  end

endmodule

// ===== rtl/scht_herm.sv =====
// Pipelined cubic Hermite interpolator: slope products, three Horner steps, round and clamp.
module scht_herm #(
  parameter int TABLE_SIZE = 512,
  parameter bit SLOPE_NEG  = 1'b0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              v_in,
  input  scht_pkg::sample_t f1,
  input  scht_pkg::sample_t f2,
  input  scht_pkg::sample_t d1,
  input  scht_pkg::sample_t d2,
  input  logic [31:0]       fr,
  output logic              v_out,
  output scht_pkg::sample_t y
);
  import scht_pkg::*;

  localparam logic [63:0] STEP = (TWO_PI_Q32 + TABLE_SIZE / 2) / TABLE_SIZE;
  localparam sample_t SLOPE_K = SLOPE_NEG ? -$signed(STEP[31:0]) : $signed(STEP[31:0]);

  logic signed [63:0] pe1, pe2;
  logic signed [32:0] dif;
  logic               v0;
  wide_t              e1_0, e2_0, df_0;
  sample_t            f1_0;
  logic [31:0]        fr_0;

  wide_t              t_st  [4];
  logic               v_st  [4];
  herm_side_t         sd_st [4];

  wide_t              ysum;
  logic signed [HW-17:0] ysh;
  sample_t            y_next;

  assign pe1 = d1 * SLOPE_K;
  assign pe2 = d2 * SLOPE_K;
  assign dif = 33'(f2) - 33'(f1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0      <= 1'b0;
      v_st[0] <= 1'b0;
    end else begin
      v0      <= v_in;
      v_st[0] <= v0;
    end
    e1_0 <= HW'(pe1 >>> 16);
    e2_0 <= HW'(pe2 >>> 16);
    df_0 <= HW'(dif) <<< 16;
    f1_0 <= f1;
    fr_0 <= fr;
    t_st[0]     <= e1_0 + e2_0 - (df_0 <<< 1);
    sd_st[0].c2 <= df_0 + (df_0 <<< 1) - e2_0 - (e1_0 <<< 1);
    sd_st[0].e1 <= e1_0;
    sd_st[0].f1 <= f1_0;
    sd_st[0].fr <= fr_0;
  end

  // Each step: t = trunc(t * fr / 2^32) + addend, in sign-magnitude form
  for (genvar k = 0; k < 3; k++) begin : g_step
    logic               va, vb, vc;
    logic               sa, sb, sc;
    logic [MW-1:0]      ma;
    logic [LW+31:0]     pl;
    logic [MW-LW+31:0]  ph;
    logic [MW-1:0]      qc;
    logic [MW+31:0]     full;
    herm_side_t         sda, sdb, sdc;
    wide_t              addend;

    assign full = {ph, {LW{1'b0}}} + (MW+32)'(pl);

    if (k == 0) begin : g_add_c2
      assign addend = sdc.c2;
    end else if (k == 1) begin : g_add_e1
      assign addend = sdc.e1;
    end else begin : g_add_none
      assign addend = '0;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        va        <= 1'b0;
        vb        <= 1'b0;
        vc        <= 1'b0;
        v_st[k+1] <= 1'b0;
      end else begin
        va        <= v_st[k];
        vb        <= va;
        vc        <= vb;
        v_st[k+1] <= vc;
      end
      sa  <= t_st[k][HW-1];
      ma  <= MW'(t_st[k][HW-1] ? -t_st[k] : t_st[k]);
      sda <= sd_st[k];
      sb  <= sa;
      pl  <= (LW+32)'(ma[LW-1:0]) * (LW+32)'(sda.fr);
      ph  <= (MW-LW+32)'(ma[MW-1:LW]) * (MW-LW+32)'(sda.fr);
      sdb <= sda;
      sc  <= sb;
      qc  <= full[MW+31:32];
      sdc <= sdb;
      t_st[k+1]  <= sc ? addend - wide_t'({1'b0, qc}) : addend + wide_t'({1'b0, qc});
      sd_st[k+1] <= sdc;
    end
  end

  // f1*2^16 has zero low bits, so adding the rounding half 2^15 is a concatenation
  assign ysum = wide_t'($signed({sd_st[3].f1, 16'h8000})) + t_st[3];
  assign ysh  = ysum[HW-1:16];

  always_comb begin
    if (ysh > ONE_Q30) begin
      y_next = ONE_Q30;
    end else if (ysh < NEG_ONE_Q30) begin
      y_next = NEG_ONE_Q30;
    end else begin
      y_next = sample_t'(ysh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_st[3];
    end
    y <= y_next;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    v_out |-> $past(v_in, HERM_LAT))
    else $error("interpolator valid out of step with its input");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    v_out |-> (y <= ONE_Q30) && (y >= NEG_ONE_Q30))
    else $error("interpolated value escaped the clamp");

endmodule

// ===== rtl/sine_cosine_hermite_table.sv =====
// Top level: angle in, sine and cosine out, fully pipelined.
// Sine and cosine of a Q4.27 angle in radians, each in Q1.30 and clamped to +/-1.
// One transaction is taken on every clock edge with start high; busy is always low.
// Each result appears, for exactly one cycle with done high, in the order the angles
// arrived; there is no way to hold it back. The pipeline consists of 4 stages of
// angle reduction, 2 stages of table read (the table is split into even and odd banks,
// each read at two addresses per cycle) and 15 stages of Hermite interpolation, plus
// the output register. TABLE_SIZE must be even.
module sine_cosine_hermite_table #(
  parameter int TABLE_SIZE = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] angle,
  output logic               done,
  output logic signed [31:0] sine,
  output logic signed [31:0] cosine
);
  import scht_pkg::*;

  localparam int IW      = $clog2(TABLE_SIZE);
  localparam int NEG_DLY = ROM_LAT + HERM_LAT;

  logic              ph_v, ph_neg;
  logic [IW-1:0]     ph_is, ph_ic;
  logic [31:0]       ph_fr;
  logic              rom_v;
  sample_t           s_lo, s_hi, c_lo, c_hi;
  logic [31:0]       rom_fr;
  logic              v_sin, v_cos;
  sample_t           y_sin, y_cos;
  logic [NEG_DLY-1:0] neg_dly;

  assign busy = 1'b0;

  scht_phase #(.TABLE_SIZE(TABLE_SIZE)) u_phase (
    .clk   (clk),
    .rst   (rst),
    .v_in  (start),
    .angle (angle),
    .v_out (ph_v),
    .neg   (ph_neg),
    .idx_s (ph_is),
    .idx_c (ph_ic),
    .fr    (ph_fr)
  );

  scht_rom #(.TABLE_SIZE(TABLE_SIZE)) u_rom (
    .clk    (clk),
    .rst    (rst),
    .v_in   (ph_v),
    .idx_s  (ph_is),
    .idx_c  (ph_ic),
    .fr_in  (ph_fr),
    .v_out  (rom_v),
    .s_lo   (s_lo),
    .s_hi   (s_hi),
    .c_lo   (c_lo),
    .c_hi   (c_hi),
    .fr_out (rom_fr)
  );

  scht_herm #(.TABLE_SIZE(TABLE_SIZE), .SLOPE_NEG(1'b0)) u_herm_sin (
    .clk   (clk),
    .rst   (rst),
    .v_in  (rom_v),
    .f1    (s_lo),
    .f2    (s_hi),
    .d1    (c_lo),
    .d2    (c_hi),
    .fr    (rom_fr),
    .v_out (v_sin),
    .y     (y_sin)
  );

  // cosine slope is minus sine: the interpolator negates its slope constant
  scht_herm #(.TABLE_SIZE(TABLE_SIZE), .SLOPE_NEG(1'b1)) u_herm_cos (
    .clk   (clk),
    .rst   (rst),
    .v_in  (rom_v),
    .f1    (c_lo),
    .f2    (c_hi),
    .d1    (s_lo),
    .d2    (s_hi),
    .fr    (rom_fr),
    .v_out (v_cos),
    .y     (y_cos)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v_sin;
    end
    neg_dly <= {neg_dly[NEG_DLY-2:0], ph_neg};
    // negate after the clamp so odd symmetry is exact
    sine    <= neg_dly[NEG_DLY-1] ? -y_sin : y_sin;
    cosine  <= y_cos;
  end

  a_lockstep: assert property (@(posedge clk) disable iff (rst) v_sin == v_cos)
    else $error("sine and cosine interpolators out of step");

  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, TOTAL_LAT))
    else $error("result without a matching transaction");

endmodule
